>>> src/sbps_pkg.sv
`timescale 1ns / 1ps

package sbps_pkg;

	localparam logic [7:0]  PINS_LR_MASK   = 8'h30;
	localparam logic [7:0]  PINS_UD_MASK   = 8'h0C;
	localparam logic [7:0]  PINS_UDLR_MASK = 8'h3C;
	localparam logic [15:0] KEEP_A_START   = 16'hFE7E;
	localparam logic [15:0] KEEP_UDLRBC    = 16'hFF81;
	localparam logic [15:0] KEEP_ZYXM      = 16'hE1FF;
	localparam logic [15:0] ACC_ALL_ONES   = 16'hFFFF;

	typedef enum logic [2:0] {
		PH_WAIT_LOW = 3'd0,
		PH_HIGH_1   = 3'd1,
		PH_LOW_2    = 3'd2,
		PH_HIGH_2   = 3'd3,
		PH_LOW_3    = 3'd4,
		PH_ID_HIGH  = 3'd5
	} phase_t;

	typedef struct packed {
		logic       select_line;
		logic [5:0] data_lines;
	} sample_t;

	typedef struct packed {
		logic        emit;
		logic [15:0] button_word;
	} result_t;

endpackage

>>> src/sbps_phase_engine.sv
`timescale 1ns / 1ps

module sbps_phase_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  sbps_pkg::sample_t sample,
	output sbps_pkg::result_t result
);

	sbps_pkg::phase_t phase_q;
	sbps_pkg::phase_t phase_d;
	logic [15:0]      acc_q;
	logic [15:0]      acc_d;
	logic [15:0]      acc_next;
	logic [7:0]       p;
	logic             sel_high;
	logic             lr_low;
	logic             ud_low;
	logic             all_low;
	logic             emit;

	assign p        = {sample.data_lines, 2'b00};
	assign sel_high = sample.select_line;
	assign lr_low   = (p & sbps_pkg::PINS_LR_MASK) == 8'h00;
	assign ud_low   = (p & sbps_pkg::PINS_UD_MASK) == 8'h00;
	assign all_low  = (p & sbps_pkg::PINS_UDLR_MASK) == 8'h00;

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			sbps_pkg::PH_HIGH_1: begin
				if (sel_high && !lr_low) phase_d = sbps_pkg::PH_LOW_2;
			end
			sbps_pkg::PH_HIGH_2: begin
				if (sel_high && !lr_low) phase_d = sbps_pkg::PH_LOW_3;
			end
			sbps_pkg::PH_LOW_2: begin
				if (!sel_high && lr_low)
					phase_d = all_low ? sbps_pkg::PH_ID_HIGH : sbps_pkg::PH_HIGH_2;
			end
			sbps_pkg::PH_LOW_3: begin
				if (!sel_high && lr_low)
					phase_d = all_low ? sbps_pkg::PH_ID_HIGH : sbps_pkg::PH_WAIT_LOW;
			end
			sbps_pkg::PH_ID_HIGH: begin
				if (sel_high && !all_low) phase_d = sbps_pkg::PH_WAIT_LOW;
			end
			default: begin
				phase_d = (!sel_high && lr_low && !ud_low) ? sbps_pkg::PH_HIGH_1
					: sbps_pkg::PH_WAIT_LOW;
			end
		endcase
	end

	// capture and emit
	always_comb begin
		acc_next = acc_q;
		emit     = 1'b0;
		unique case (phase_q)
			sbps_pkg::PH_HIGH_1, sbps_pkg::PH_HIGH_2: begin
				if (sel_high && !lr_low)
					acc_next = acc_q & (sbps_pkg::KEEP_UDLRBC | {9'h000, p[7:1]});
			end
			sbps_pkg::PH_LOW_2: begin
				if (!sel_high && lr_low && !all_low)
					acc_next = acc_q & (sbps_pkg::KEEP_A_START | {7'h00, p, 1'b0});
			end
			sbps_pkg::PH_LOW_3: begin
				if (!sel_high && lr_low && !all_low) emit = 1'b1;
			end
			sbps_pkg::PH_ID_HIGH: begin
				if (sel_high && !all_low) begin
					acc_next = acc_q & (sbps_pkg::KEEP_ZYXM | {1'b0, p, 7'h00});
					emit     = 1'b1;
				end
			end
			default: begin
				if (!sel_high && lr_low && !ud_low)
					acc_next = acc_q & (sbps_pkg::KEEP_A_START | {7'h00, p, 1'b0});
			end
		endcase
		acc_d              = emit ? sbps_pkg::ACC_ALL_ONES : acc_next;
		result.emit        = emit;
		result.button_word = ~acc_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sbps_pkg::PH_WAIT_LOW;
			acc_q   <= sbps_pkg::ACC_ALL_ONES;
		end else if (step) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
		end
	end

endmodule

>>> src/sbps_out_reg.sv
`timescale 1ns / 1ps

module sbps_out_reg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  logic [15:0] word,
	output logic        space,
	output logic        tvalid,
	input  logic        tready,
	output logic [15:0] tdata
);

	logic        valid_q;
	logic [15:0] word_q;

	assign space  = !valid_q || tready;
	assign tvalid = valid_q;
	assign tdata  = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (space && load) word_q <= word;
	end

endmodule

>>> src/six_button_pad_snooper.sv
`timescale 1ns / 1ps

// channel   dir  width  fields (lowest bit up)
// s_axis    in   8      select_line, data_lines[5:0], pad
// m_axis    out  16     button_word
//
// one pin sample a cycle unless a completing sample waits on a stalled output; a sample
// is registered; a completed word enters the output register as its last sample leaves
// arst_n clears the phase to waiting for the first low phase and the accumulator to ones
// a stalled output holds only samples that complete a word; other samples keep flowing

module six_button_pad_snooper (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // select_line, data_lines[5:0], zero pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // button_word
);

	logic              valid_s1;
	sbps_pkg::sample_t sample_s1;
	sbps_pkg::result_t result;
	logic              space;
	logic              consume;

	assign consume       = valid_s1 && (!result.emit || space);
	assign s_axis_tready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			sample_s1.select_line <= s_axis_tdata[0];
			sample_s1.data_lines  <= s_axis_tdata[6:1];
		end
	end

	sbps_phase_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (consume),
		.sample (sample_s1),
		.result (result)
	);

	sbps_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (consume && result.emit),
		.word   (result.button_word),
		.space  (space),
		.tvalid (m_axis_tvalid),
		.tready (m_axis_tready),
		.tdata  (m_axis_tdata)
	);

endmodule
